FILE: rtl/mri_pkg.sv
// Shared types and constants for the midpoint reciprocal integrator.
package mri_pkg;

   localparam int BOUND_W = 32;
   localparam int COUNT_W = 21;
   localparam int STATUS_W = 2;
   localparam int DIV_W = 64;
   localparam int ACC_W = 64;

   localparam logic signed [ACC_W-1:0] ACC_LIMIT = 64'sh4000_0000_0000_0000;
   localparam logic signed [ACC_W-1:0] AREA_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] AREA_MIN = -64'sh0000_0000_8000_0000;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DIV = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

   typedef enum logic {
      DIV_SEL_OFFSET,
      DIV_SEL_TERM
   } div_sel_type;

   typedef enum logic {
      RSP_SEL_SUM,
      RSP_SEL_DIVZ
   } rsp_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        div_start;
      div_sel_type div_sel;
      logic        mid_load;
      logic        prod_load;
      logic        acc_step;
      logic        load_rsp;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic mid_zero;
      logic div_done;
      logic last_step;
   } sts_type;

endpackage

FILE: rtl/mri_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module mri_div
   import mri_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   rem_sh;
   logic [DIV_W:0]   rem_sub;

   assign rem_sh = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!rem_sub[DIV_W]) begin
            rem_in = rem_sub[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done = done_ff;

endmodule

FILE: rtl/mri_datapath.sv
// Datapath: bounds, midpoint, product, accumulator, divider and result register.
module mri_datapath
   import mri_pkg::*;
#(
   parameter int MAX_INTERVALS = 1048576,
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic signed [BOUND_W-1:0]  req_range_start,
   input  logic signed [BOUND_W-1:0]  req_range_end,
   input  logic [COUNT_W-1:0]         req_interval_count,
   output logic signed [BOUND_W-1:0]  rsp_area_estimate,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam logic [24:0] MAX_N = 25'(MAX_INTERVALS);

   logic signed [BOUND_W-1:0] a_ff;
   logic [COUNT_W-1:0]        n_ff, n_in;
   logic                      d_neg_ff;
   logic [BOUND_W:0]          d_mag_ff, d_mag_in;
   logic [DIV_W-1:0]          num_ff;
   logic [COUNT_W-1:0]        i_ff;
   logic signed [BOUND_W-1:0] mid_ff;
   logic [DIV_W-1:0]          prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [BOUND_W-1:0] area_ff;
   logic [STATUS_W-1:0]       status_ff;

   logic signed [BOUND_W:0]   d_full;
   logic [DIV_W-1:0]          div_dividend;
   logic [DIV_W-1:0]          div_divisor;
   logic [DIV_W-1:0]          div_quo;
   logic                      div_done;
   logic [BOUND_W+1:0]        off_w;
   logic [BOUND_W+1:0]        mid_w;
   logic [BOUND_W-1:0]        mid_mag;
   logic [52:0]               prod_w;
   logic signed [ACC_W-1:0]   term_s;
   logic signed [ACC_W:0]     sum_w;

   mri_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .done     (div_done)
   );

   always_comb begin
      d_full = {req_range_end[BOUND_W-1], req_range_end}
             - {req_range_start[BOUND_W-1], req_range_start};
      d_mag_in = d_full[BOUND_W] ? (BOUND_W+1)'(-d_full) : d_full;
      if ({4'b0, req_interval_count} > MAX_N) begin
         n_in = COUNT_W'(MAX_N);
      end else begin
         n_in = req_interval_count;
      end
   end

   always_comb begin
      if (cmd.div_sel == DIV_SEL_OFFSET) begin
         div_dividend = num_ff;
         div_divisor = DIV_W'({n_ff, 1'b0});
      end else begin
         div_dividend = DIV_W'(d_mag_ff) << FRAC_BITS;
         div_divisor = prod_ff;
      end
   end

   always_comb begin
      off_w = d_neg_ff ? -{1'b0, div_quo[BOUND_W:0]} : {1'b0, div_quo[BOUND_W:0]};
      mid_w = {{2{a_ff[BOUND_W-1]}}, a_ff} + off_w;
      mid_mag = mid_ff[BOUND_W-1] ? BOUND_W'(-mid_ff) : mid_ff;
      prod_w = n_ff * mid_mag;
      term_s = (d_neg_ff ^ mid_ff[BOUND_W-1]) ? -$signed(div_quo) : $signed(div_quo);
      sum_w = {acc_ff[ACC_W-1], acc_ff} + {term_s[ACC_W-1], term_s};
      if (sum_w > $signed({1'b0, ACC_LIMIT})) begin
         acc_in = ACC_LIMIT;
      end else if (sum_w < -$signed({1'b0, ACC_LIMIT})) begin
         acc_in = -ACC_LIMIT;
      end else begin
         acc_in = sum_w[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         a_ff <= req_range_start;
         n_ff <= n_in;
         d_neg_ff <= d_full[BOUND_W];
         d_mag_ff <= d_mag_in;
         num_ff <= DIV_W'(d_mag_in);
         i_ff <= '0;
         acc_ff <= '0;
      end
      if (cmd.mid_load) begin
         mid_ff <= mid_w[BOUND_W-1:0];
      end
      if (cmd.prod_load) begin
         prod_ff <= DIV_W'(prod_w);
      end
      if (cmd.acc_step) begin
         acc_ff <= acc_in;
         num_ff <= num_ff + DIV_W'({d_mag_ff, 1'b0});
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.load_rsp) begin
         if (cmd.rsp_sel == RSP_SEL_DIVZ) begin
            area_ff <= '0;
            status_ff <= STATUS_DIV;
         end else if (acc_ff > AREA_MAX) begin
            area_ff <= AREA_MAX[BOUND_W-1:0];
            status_ff <= STATUS_SAT;
         end else if (acc_ff < AREA_MIN) begin
            area_ff <= AREA_MIN[BOUND_W-1:0];
            status_ff <= STATUS_SAT;
         end else begin
            area_ff <= acc_ff[BOUND_W-1:0];
            status_ff <= STATUS_OK;
         end
      end
   end

   assign sts.n_zero = (n_ff == '0);
   assign sts.mid_zero = (mid_ff == '0);
   assign sts.div_done = div_done;
   assign sts.last_step = (i_ff == n_ff - 1'b1);

   assign rsp_area_estimate = area_ff;
   assign rsp_status = status_ff;

endmodule

FILE: rtl/mri_ctrl.sv
// Controller state machine that sequences the intervals of one request.
module mri_ctrl
   import mri_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_OFF_START,
      ST_OFF_WAIT,
      ST_MID,
      ST_MUL,
      ST_TERM_START,
      ST_TERM_WAIT,
      ST_ACC,
      ST_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_sel_type sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.div_sel = DIV_SEL_OFFSET;
      cmd.rsp_sel = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.n_zero) begin
               sel_in = RSP_SEL_DIVZ;
               state_in = ST_FINISH;
            end else begin
               sel_in = RSP_SEL_SUM;
               state_in = ST_OFF_START;
            end
         end
         ST_OFF_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_OFF_WAIT;
         end
         ST_OFF_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            cmd.mid_load = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (sts.mid_zero) begin
               sel_in = RSP_SEL_DIVZ;
               state_in = ST_FINISH;
            end else begin
               cmd.prod_load = 1'b1;
               state_in = ST_TERM_START;
            end
         end
         ST_TERM_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = DIV_SEL_TERM;
            state_in = ST_TERM_WAIT;
         end
         ST_TERM_WAIT: begin
            cmd.div_sel = DIV_SEL_TERM;
            if (sts.div_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.div_sel = DIV_SEL_TERM;
            cmd.acc_step = 1'b1;
            state_in = sts.last_step ? ST_FINISH : ST_OFF_START;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sel_ff <= RSP_SEL_SUM;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff <= sel_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/midpoint_rule_reciprocal_integral.sv
// Top level of the midpoint rectangle-rule integrator of 1/x.
// Each request returns the midpoint-rule sum of 1/x from range_start to
// range_end over interval_count rectangles, in signed fixed point with
// FRAC_BITS fraction bits; counts above MAX_INTERVALS are clamped. A zero
// count or a zero midpoint gives status 1 and a zero estimate, and a sum
// outside 32 bits is saturated with status 2. Each interval uses the single
// bit-serial divider twice, once for the midpoint offset and once for the
// term; the divider delivers one quotient bit per cycle. A zero midpoint
// ends the request at that interval. A finished result waits in an output
// register, and the next request is accepted while it waits.
module midpoint_rule_reciprocal_integral
   import mri_pkg::*;
#(
   parameter int MAX_INTERVALS = 1048576,
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [BOUND_W-1:0] req_range_start,
   input  logic signed [BOUND_W-1:0] req_range_end,
   input  logic [COUNT_W-1:0]        req_interval_count,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [BOUND_W-1:0] rsp_area_estimate,
   output logic [STATUS_W-1:0]       rsp_status
);

   cmd_type cmd;
   sts_type sts;

   mri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mri_datapath #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .FRAC_BITS     (FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_range_start    (req_range_start),
      .req_range_end      (req_range_end),
      .req_interval_count (req_interval_count),
      .rsp_area_estimate  (rsp_area_estimate),
      .rsp_status         (rsp_status)
   );

   // An accepted request keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous request still starting");

   // A division status always carries a zero estimate.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DIV |-> rsp_area_estimate == '0)
      else $error("division status with nonzero estimate");

   // A saturated result sits at one end of the 32-bit range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_SAT |->
         rsp_area_estimate == 32'sh7FFF_FFFF || rsp_area_estimate == 32'sh8000_0000)
      else $error("saturated status with in-range estimate");

   // A waiting result is never overwritten before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_area_estimate)
         && $stable(rsp_status))
      else $error("pending result changed before it was taken");

endmodule

FILE: dv/tb_midpoint_rule_reciprocal_integral.sv
// Self-checking testbench for the midpoint-rule integrator of 1/x.
`timescale 1ns / 100ps

module tb_midpoint_rule_reciprocal_integral;
   import mri_pkg::*;

   localparam longint MAX_INTERVALS = 1048576;
   localparam int FRAC_BITS = 16;
   localparam int RANDOM_REQUESTS = 400;
   localparam int CYCLE_LIMIT = 8000000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic signed [BOUND_W-1:0] area;
      logic [STATUS_W-1:0]       status;
   } area_result_type;

   class area_scoreboard;
      area_result_type expected_areas[$];
      int errors = 0;
      int checked = 0;
      int div_seen = 0;
      int sat_seen = 0;

      function area_result_type predict_area(logic signed [BOUND_W-1:0] lo,
                                             logic signed [BOUND_W-1:0] hi,
                                             logic [COUNT_W-1:0] count_raw);
         longint a, b, n, d, off, mid, term, acc, i;
         area_result_type r;
         a = lo;
         b = hi;
         n = count_raw;
         r.area = '0;
         r.status = STATUS_DIV;
         if (n > MAX_INTERVALS) n = MAX_INTERVALS;
         if (n == 0) return r;
         d = b - a;
         acc = 0;
         for (i = 0; i < n; i++) begin
            off = (d * (2 * i + 1)) / (2 * n);
            mid = a + off;
            if (mid == 0) return r;
            term = (d * (longint'(1) <<< FRAC_BITS)) / (n * mid);
            acc = acc + term;
            if (acc > ACC_LIMIT) acc = ACC_LIMIT;
            if (acc < -ACC_LIMIT) acc = -ACC_LIMIT;
         end
         r.status = STATUS_OK;
         if (acc > AREA_MAX) begin
            acc = AREA_MAX;
            r.status = STATUS_SAT;
         end else if (acc < AREA_MIN) begin
            acc = AREA_MIN;
            r.status = STATUS_SAT;
         end
         r.area = acc[BOUND_W-1:0];
         return r;
      endfunction

      function void note_request(logic signed [BOUND_W-1:0] lo,
                                 logic signed [BOUND_W-1:0] hi,
                                 logic [COUNT_W-1:0] count_raw);
         expected_areas.push_back(predict_area(lo, hi, count_raw));
      endfunction

      function void check_result(logic signed [BOUND_W-1:0] area,
                                 logic [STATUS_W-1:0] status);
         area_result_type exp_r;
         if (expected_areas.size() == 0) begin
            $error("Result with no pending request: area_estimate %0d status %0d",
                   area, status);
            errors++;
            return;
         end
         exp_r = expected_areas.pop_front();
         checked++;
         if (exp_r.status == STATUS_DIV) div_seen++;
         if (exp_r.status == STATUS_SAT) sat_seen++;
         if (area !== exp_r.area) begin
            $error("area_estimate: expected %0d, actual %0d", exp_r.area, area);
            errors++;
         end
         if (status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [BOUND_W-1:0] req_range_start = '0;
   logic signed [BOUND_W-1:0] req_range_end = '0;
   logic [COUNT_W-1:0] req_interval_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [BOUND_W-1:0] rsp_area_estimate;
   logic [STATUS_W-1:0] rsp_status;

   int send_idle_pct = 11;
   int recv_idle_pct = 69;
   int requests_sent = 0;
   int cycle_count = 0;
   area_scoreboard sb;

   midpoint_rule_reciprocal_integral #(
      .MAX_INTERVALS(1048576),
      .FRAC_BITS(16)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_range_start(req_range_start),
      .req_range_end(req_range_end),
      .req_interval_count(req_interval_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_area_estimate(rsp_area_estimate),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_area_estimate, rsp_status);
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, sb.expected_areas.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_request(input int lo, input int hi, input int count);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_range_start <= lo;
      req_range_end <= hi;
      req_interval_count <= count[COUNT_W-1:0];
      do @(posedge clock); while (!req_ready);
      sb.note_request(lo, hi, count[COUNT_W-1:0]);
      requests_sent++;
   endtask

   task automatic random_request();
      int lo, hi, count, eff, sel;
      sel = $urandom_range(0, 99);
      lo = $urandom;
      hi = $urandom;
      count = $urandom_range(1, 12);
      if (sel < 15) begin
         lo = -int'($urandom_range(0, 400));
         hi = $urandom_range(0, 400);
         if ($urandom_range(0, 1)) begin
            eff = lo;
            lo = hi;
            hi = eff;
         end
      end else if (sel < 25) begin
         count = $urandom_range(13, 48);
      end else if (sel < 35) begin
         // The first midpoint lands on zero, so even a huge count ends at once.
         count = $urandom_range(1, 2097151);
         eff = (count > MAX_INTERVALS) ? int'(MAX_INTERVALS) : count;
         lo = 0;
         hi = $urandom_range(0, 2 * eff - 1);
         if ($urandom_range(0, 1)) hi = -hi;
      end else if (sel < 40) begin
         count = 0;
      end
      send_request(lo, hi, count);
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(32'h0001_0000, 32'h0002_0000, 0);
      send_request(32'h0001_0000, 32'h0002_0000, 1);
      send_request(32'h0001_0000, 32'h0002_0000, 4);
      send_request(32'h0002_0000, 32'h0001_0000, 4);
      send_request(0, 5, 2097151);
      send_request(0, 1, 1048576);
      send_request(-3, 3, 3);
      send_request(-32'sh10_0000, 32'h10_0002, 1);
      send_request(32'h10_0002, -32'sh10_0000, 1);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 1);
      send_request(32'h7FFF_FFFF, 32'h8000_0000, 1);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 2);
      send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
      send_request(32'h8000_0000, 32'h8000_0000, 3);
      send_request(0, 0, 1);
      send_request(32'h0001_0000, 32'h000A_0000, 8);
      send_request(1, 32'h7FFF_FFFF, 1);
      send_request(-32'sh000A_0000, -32'sh0001_0000, 6);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_request(-1, 1, 1);

      for (int k = 0; k < RANDOM_REQUESTS; k++) begin
         if (k == RANDOM_REQUESTS / 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 11;
         end else if (k == 2 * RANDOM_REQUESTS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_request();
      end
      req_valid <= 1'b0;

      while (sb.expected_areas.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.expected_areas.size() != 0) begin
         $error("%0d expected results never arrived", sb.expected_areas.size());
         sb.errors++;
      end
      $display("Checked %0d results from %0d requests in %0d cycles.",
               sb.checked, requests_sent, cycle_count);
      $display("Of those, %0d hit a zero count or zero midpoint and %0d saturated.",
               sb.div_seen, sb.sat_seen);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
